// ===== hw/rtl/ptri_pkg.sv =====
package ptri_pkg;

  // Event kinds carried on the input channel's tuser.
  typedef enum logic [2:0] {
    MODE_STATUS_RD = 3'd0,
    MODE_CTRL_WR   = 3'd1,
    MODE_DATA_RD   = 3'd2,
    MODE_DATA_WR   = 3'd3,
    MODE_FRAME     = 3'd4,
    MODE_END       = 3'd5,
    MODE_LOAD      = 3'd6,
    MODE_UNLOAD    = 3'd7
  } mode_t;

  // Status register layout, most significant field first.
  typedef struct packed {
    logic       present;
    logic [1:0] spare;
    logic       binary;
    logic       busy;
    logic       done;
    logic [2:0] level;
  } status_t;

  localparam int unsigned WORD_W     = 36;
  localparam int unsigned STATUS_W   = 9;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned CTRL_W     = 6;
  localparam int unsigned FRAME_W    = 8;
  localparam int unsigned FRAME_BITS = 6;
  localparam int unsigned CNT_W      = 3;

  localparam int unsigned FRAMES_PER_WORD = 6;
  localparam logic [CNT_W-1:0] FRAME_CNT_LAST = CNT_W'(FRAMES_PER_WORD);

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 1;

endpackage

// ===== hw/rtl/paper_tape_reader_interface_unit.sv =====
// Paper tape reader controller.
// Each input transaction is one event: a host status read, control write,
// data read or data write (ignored), or a tape event (frame, end of tape,
// tape loaded, tape removed). in_tuser carries the event kind, in_tdata the
// control value and the frame byte. Every event yields exactly one output
// transaction with the read data word, the status word, the read-accepted
// flag and the interrupt request state after the event.
// Text mode fills the word from one frame; binary mode shifts in the low six
// bits of each frame that has bit 7 set until six frames are in.
// Timing: an accepted event is held in the input register, is evaluated
// against the controller state and lands in the output register, from
// which its result is offered. One event per cycle is sustained while the
// receiver takes every result; the only loop is the state update inside
// the evaluation stage. When the receiver stalls, the output register holds
// its transaction and the input register fills; in_tready then follows
// out_tready, so nothing is lost or repeated and the stream resumes at
// full rate.
// Synchronous active-low reset empties both registers, clears status, data,
// assembly word and frame count, removes the tape and drops the interrupt.
module paper_tape_reader_interface_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [5:0] control_bits, [13:6] frame_byte, [15:14] zero
  input  logic [ptri_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] mode
  input  logic [ptri_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [35:0] read_data, [44:36] status_word, [45] irq_active,
  // [48:46] irq_level, [55:49] zero
  output logic [ptri_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] read_accepted
  output logic [ptri_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import ptri_pkg::*;

  // Input register stage.
  logic               s1_vld_r;
  logic               s1_vld_nxt;
  mode_t              s1_mode_r;
  logic [CTRL_W-1:0]  s1_ctrl_r;
  logic [FRAME_W-1:0] s1_frame_r;

  // Output register stage.
  logic               out_vld_r;
  logic               out_vld_nxt;
  logic [WORD_W-1:0]  out_rdata_r;
  status_t            out_status_r;
  logic               out_acc_r;
  logic               out_irq_r;

  // Controller state.
  status_t            status_r;
  status_t            status_nxt;
  logic [WORD_W-1:0]  data_r;
  logic [WORD_W-1:0]  data_nxt;
  logic [WORD_W-1:0]  asm_r;
  logic [WORD_W-1:0]  asm_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               tape_r;
  logic               tape_nxt;
  logic               irq_r;
  logic               irq_nxt;

  logic               rdata_acc;
  logic [WORD_W-1:0]  rdata;
  logic               s1_adv;
  logic               in_acc;

  // The evaluation stage moves forward whenever the output register is free
  // or is being emptied this cycle.
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Event evaluation against the current controller state.
  always_comb begin
    logic [CNT_W-1:0] cnt_inc;
    logic             finish;
    status_nxt = status_r;
    data_nxt   = data_r;
    asm_nxt    = asm_r;
    cnt_nxt    = cnt_r;
    tape_nxt   = tape_r;
    irq_nxt    = irq_r;
    rdata      = '0;
    rdata_acc  = 1'b0;
    finish     = 1'b0;
    cnt_inc    = cnt_r + CNT_W'(1);
    case (s1_mode_r)
      MODE_CTRL_WR: begin
        status_nxt.level   = s1_ctrl_r[2:0];
        status_nxt.done    = s1_ctrl_r[3];
        status_nxt.busy    = s1_ctrl_r[4];
        status_nxt.binary  = s1_ctrl_r[5];
        status_nxt.spare   = 2'b00;
        status_nxt.present = tape_r;
        irq_nxt            = s1_ctrl_r[3];
        if (s1_ctrl_r[4]) begin
          data_nxt = '0;
          asm_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      MODE_DATA_RD: begin
        if (status_r.done) begin
          rdata           = data_r;
          rdata_acc       = 1'b1;
          status_nxt.busy = 1'b1;
          status_nxt.done = 1'b0;
          irq_nxt         = 1'b0;
          asm_nxt         = '0;
          cnt_nxt         = '0;
        end
      end
      MODE_FRAME: begin
        if (status_r.busy && tape_r) begin
          if (status_r.binary) begin
            // Frames without the punch in channel eight are leader or
            // filler and are skipped.
            if (s1_frame_r[7]) begin
              asm_nxt = {asm_r[WORD_W-FRAME_BITS-1:0], s1_frame_r[FRAME_BITS-1:0]};
              cnt_nxt = cnt_inc;
              finish  = (cnt_inc >= FRAME_CNT_LAST);
            end
          end else begin
            asm_nxt = {{(WORD_W-FRAME_W){1'b0}}, s1_frame_r};
            finish  = 1'b1;
          end
        end
      end
      MODE_END: begin
        if (status_r.busy && tape_r) begin
          status_nxt.present = 1'b0;
          finish             = 1'b1;
        end
      end
      MODE_LOAD: begin
        tape_nxt           = 1'b1;
        status_nxt.present = 1'b1;
      end
      MODE_UNLOAD: begin
        tape_nxt           = 1'b0;
        status_nxt.present = 1'b0;
      end
      default: begin
      end
    endcase
    if (finish) begin
      data_nxt        = asm_nxt;
      status_nxt.busy = 1'b0;
      status_nxt.done = 1'b1;
      irq_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      status_r  <= '0;
      data_r    <= '0;
      asm_r     <= '0;
      cnt_r     <= '0;
      tape_r    <= 1'b0;
      irq_r     <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_adv) begin
        status_r <= status_nxt;
        data_r   <= data_nxt;
        asm_r    <= asm_nxt;
        cnt_r    <= cnt_nxt;
        tape_r   <= tape_nxt;
        irq_r    <= irq_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r  <= mode_t'(in_tuser[2:0]);
      s1_ctrl_r  <= in_tdata[CTRL_W-1:0];
      s1_frame_r <= in_tdata[CTRL_W+FRAME_W-1:CTRL_W];
    end
    if (s1_adv) begin
      out_rdata_r  <= rdata;
      out_status_r <= status_nxt;
      out_acc_r    <= rdata_acc;
      out_irq_r    <= irq_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W-WORD_W-STATUS_W-1-LEVEL_W){1'b0}},
                       out_status_r.level, out_irq_r, out_status_r, out_rdata_r};
  assign out_tuser  = out_acc_r;

endmodule

// ===== hw/rtl/ptri_checker.sv =====
module ptri_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [ptri_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [ptri_pkg::OUT_TUSER_W-1:0]   out_tuser
);
  import ptri_pkg::*;

  // A held output transaction stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output transaction changed while stalled");

  // The reported interrupt level always mirrors the status level field.
  a_irq_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[48:46] == out_tdata[38:36])
    else $error("irq level differs from status level");

  // Read data is only driven on an accepted data read.
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[WORD_W-1:0] == '0)
    else $error("read data nonzero without accepted read");

  // An accepted read starts the next word: busy set, done and irq cleared.
  a_read_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[40] && !out_tdata[39] && !out_tdata[45])
    else $error("accepted read did not restart the reader");

  // Spare status bits and the tdata padding above the level never get set.
  a_spare_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[43:42] == 2'b00 && out_tdata[55:49] == '0)
    else $error("spare status or padding bits set");

endmodule

bind paper_tape_reader_interface_unit ptri_checker u_ptri_checker (.*);

// ===== test/tb_paper_tape_reader_interface_unit.sv =====
`timescale 1ns / 100ps

module tb_paper_tape_reader_interface_unit;
  import ptri_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned ITEMS_PER_LOAD = 275;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned PRINT_LIMIT    = 40;

  // One event as it travels on the input channel.
  typedef struct packed {
    mode_t               mode;
    logic [CTRL_W-1:0]   ctl;
    logic [FRAME_W-1:0]  frame;
  } tape_event_t;

  // One reply as the controller should report it.
  typedef struct packed {
    logic [WORD_W-1:0]   rdata;
    status_t             status;
    logic                accepted;
    logic                irq;
    logic [LEVEL_W-1:0]  level;
  } reply_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic [IN_TUSER_W-1:0]   in_tuser = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [OUT_TUSER_W-1:0]  out_tuser;

  paper_tape_reader_interface_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Shadow copy of the controller state, advanced once per accepted event.
  status_t             sh_status;
  logic [WORD_W-1:0]   sh_word;
  logic [WORD_W-1:0]   sh_build;
  logic [CNT_W-1:0]    sh_frames;
  logic                sh_tape;
  logic                sh_irq;

  tape_event_t event_backlog[$];
  reply_t      expected_replies[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned pushed_total = 0;
  int unsigned accepted_total = 0;
  int unsigned replies_checked = 0;
  int unsigned reads_taken = 0;
  int unsigned irq_replies = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  logic        in_taken = 1'b0;
  tape_event_t drive_ev;
  tape_event_t seen_ev;
  reply_t      want;
  reply_t      got;

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("MISMATCH %s on reply %0d: got 0x%0h, expected 0x%0h",
               what, replies_checked, seen, wanted);
  endtask

  // A word is complete: latch it, flip busy to done and raise the request.
  task automatic close_word();
    sh_word = sh_build;
    sh_status.busy = 1'b0;
    sh_status.done = 1'b1;
    sh_irq = 1'b1;
  endtask

  task automatic advance_reader(input tape_event_t ev, output reply_t r);
    logic reading;
    reading = sh_status.busy;
    r = '0;
    case (ev.mode)
      MODE_CTRL_WR: begin
        sh_irq = 1'b0;
        sh_status = status_t'({3'b000, ev.ctl});
        sh_status.present = sh_tape;
        if (sh_status.busy) begin
          sh_word = '0;
          sh_build = '0;
          sh_frames = '0;
        end
        if (sh_status.done)
          sh_irq = 1'b1;
      end
      MODE_DATA_RD: begin
        if (sh_status.done) begin
          r.rdata = sh_word;
          r.accepted = 1'b1;
          sh_status.busy = 1'b1;
          sh_status.done = 1'b0;
          sh_irq = 1'b0;
          sh_build = '0;
          sh_frames = '0;
        end
      end
      MODE_FRAME: begin
        if (reading && sh_tape) begin
          if (sh_status.binary) begin
            // Frames without the sprocket bit 7 are skipped in binary mode.
            if (ev.frame[7]) begin
              sh_build = {sh_build[WORD_W-FRAME_BITS-1:0], ev.frame[FRAME_BITS-1:0]};
              sh_frames = sh_frames + 1'b1;
              if (sh_frames >= FRAME_CNT_LAST)
                close_word();
            end
          end else begin
            sh_build = WORD_W'(ev.frame);
            close_word();
          end
        end
      end
      MODE_END: begin
        if (reading && sh_tape) begin
          sh_status.present = 1'b0;
          close_word();
        end
      end
      MODE_LOAD: begin
        sh_tape = 1'b1;
        sh_status.present = 1'b1;
      end
      MODE_UNLOAD: begin
        sh_tape = 1'b0;
        sh_status.present = 1'b0;
      end
      default: ;
    endcase
    r.status = sh_status;
    r.irq = sh_irq;
    r.level = sh_status.level;
  endtask

  task automatic push_event(input mode_t m, input logic [CTRL_W-1:0] c,
                            input logic [FRAME_W-1:0] f);
    tape_event_t ev;
    ev.mode = m;
    ev.ctl = c;
    ev.frame = f;
    event_backlog.push_back(ev);
    pushed_total++;
  endtask

  task automatic push_noise();
    push_event(mode_t'($urandom_range(0, 7)), CTRL_W'($urandom_range(0, 63)),
               FRAME_W'($urandom_range(0, 255)));
  endtask

  // A typical host session: load, arm the reader, pull a few words, and
  // sometimes run off the end of the tape or pull it out.
  task automatic push_session();
    logic [CTRL_W-1:0] c;
    int unsigned       words;
    int unsigned       got_frames;
    bit                cut_short;
    cut_short = 1'b0;
    if ($urandom_range(0, 9) != 0)
      push_event(MODE_LOAD, CTRL_W'($urandom), FRAME_W'($urandom));
    c = CTRL_W'($urandom_range(0, 63));
    if ($urandom_range(0, 7) != 0)
      c[4] = 1'b1;
    push_event(MODE_CTRL_WR, c, FRAME_W'($urandom));
    words = $urandom_range(1, 4);
    for (int unsigned w = 0; w < words && !cut_short; w++) begin
      if (c[5]) begin
        got_frames = 0;
        while (got_frames < FRAMES_PER_WORD && !cut_short) begin
          if ($urandom_range(0, 4) == 0)
            push_event(MODE_FRAME, CTRL_W'($urandom), {1'b0, 7'($urandom)});
          if ($urandom_range(0, 15) == 0)
            push_event(MODE_STATUS_RD, CTRL_W'($urandom), FRAME_W'($urandom));
          if ($urandom_range(0, 19) == 0) begin
            push_event(MODE_END, CTRL_W'($urandom), FRAME_W'($urandom));
            cut_short = 1'b1;
          end else begin
            push_event(MODE_FRAME, CTRL_W'($urandom), {1'b1, 7'($urandom)});
            got_frames++;
          end
        end
      end else begin
        if ($urandom_range(0, 11) == 0) begin
          push_event(MODE_END, CTRL_W'($urandom), FRAME_W'($urandom));
          cut_short = 1'b1;
        end else begin
          push_event(MODE_FRAME, CTRL_W'($urandom), FRAME_W'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 9) == 0)
        push_event(MODE_DATA_WR, CTRL_W'($urandom), FRAME_W'($urandom));
      if ($urandom_range(0, 9) != 0)
        push_event(MODE_DATA_RD, CTRL_W'($urandom), FRAME_W'($urandom));
    end
    if ($urandom_range(0, 5) == 0)
      push_event(MODE_UNLOAD, CTRL_W'($urandom), FRAME_W'($urandom));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) push_noise();
  endtask

  task automatic push_directed();
    push_event(MODE_STATUS_RD, 6'h00, 8'h00);
    push_event(MODE_DATA_RD,   6'h3F, 8'hFF);  // done is clear, so nothing happens
    push_event(MODE_FRAME,     6'h00, 8'hFF);  // no read and no tape
    push_event(MODE_END,       6'h00, 8'h00);  // no read in progress
    push_event(MODE_CTRL_WR,   6'h10, 8'h00);  // busy, but no tape is loaded
    push_event(MODE_FRAME,     6'h00, 8'hC5);  // reading without tape: ignored
    push_event(MODE_LOAD,      6'h00, 8'h00);
    push_event(MODE_CTRL_WR,   6'h3F, 8'h00);  // level 7, done, busy, binary
    push_event(MODE_FRAME,     6'h00, 8'hFF);
    push_event(MODE_FRAME,     6'h00, 8'h7F);  // no sprocket bit: skipped
    push_event(MODE_FRAME,     6'h00, 8'h80);
    push_event(MODE_FRAME,     6'h00, 8'hBF);
    push_event(MODE_FRAME,     6'h00, 8'h00);  // skipped as well
    push_event(MODE_FRAME,     6'h00, 8'hC0);
    push_event(MODE_FRAME,     6'h00, 8'hAA);
    push_event(MODE_FRAME,     6'h00, 8'h95);  // sixth frame completes the word
    push_event(MODE_DATA_WR,   6'h3F, 8'hFF);
    push_event(MODE_DATA_RD,   6'h00, 8'h00);  // taken, next read starts
    push_event(MODE_FRAME,     6'h00, 8'hE1);
    push_event(MODE_END,       6'h00, 8'h00);  // partial word, tape present drops
    push_event(MODE_DATA_RD,   6'h00, 8'h00);
    push_event(MODE_CTRL_WR,   6'h10, 8'h00);  // text, level 0: present comes back
    push_event(MODE_FRAME,     6'h00, 8'h00);  // interrupt pending at level zero
    push_event(MODE_FRAME,     6'h00, 8'hFF);  // busy is clear now: ignored
    push_event(MODE_UNLOAD,    6'h00, 8'h00);
    push_event(MODE_CTRL_WR,   6'h00, 8'h00);
  endtask

  // Driver: offers the next event at the falling edge once the previous
  // transaction has completed, with random idle cycles between events.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
    end else if (!in_tvalid || in_taken) begin
      if (event_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drive_ev = event_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, drive_ev.frame, drive_ev.ctl};
        in_tuser <= drive_ev.mode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      if (hold_left > 0)
        hold_left = hold_left - 1;
    end
  end

  // Monitor: predicts on every input transaction and checks every output
  // transaction against the oldest expected reply.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        seen_ev.mode = mode_t'(in_tuser);
        seen_ev.ctl = in_tdata[CTRL_W-1:0];
        seen_ev.frame = in_tdata[CTRL_W+FRAME_W-1:CTRL_W];
        advance_reader(seen_ev, want);
        expected_replies.push_back(want);
        accepted_total++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected reply", {8'h00, out_tdata}, 64'd0);
        end else begin
          want = expected_replies.pop_front();
          got.rdata = out_tdata[35:0];
          got.status = status_t'(out_tdata[44:36]);
          got.irq = out_tdata[45];
          got.level = out_tdata[48:46];
          got.accepted = out_tuser[0];
          if (got.rdata !== want.rdata)
            report_mismatch("read_data", 64'(got.rdata), 64'(want.rdata));
          if (got.status !== want.status)
            report_mismatch("status_word", 64'(got.status), 64'(want.status));
          if (got.irq !== want.irq)
            report_mismatch("irq_active", 64'(got.irq), 64'(want.irq));
          if (got.level !== want.level)
            report_mismatch("irq_level", 64'(got.level), 64'(want.level));
          if (got.accepted !== want.accepted)
            report_mismatch("read_accepted", 64'(got.accepted), 64'(want.accepted));
          if (out_tdata[55:49] !== '0)
            report_mismatch("tdata padding", 64'(out_tdata[55:49]), 64'd0);
          if (want.accepted)
            reads_taken++;
          if (want.irq)
            irq_replies++;
          replies_checked++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding",
               cycle_count, expected_replies.size());
      $display("tb_paper_tape_reader_interface_unit: done, errors");
      $finish;
    end
  end

  // Four load phases: no idling, sender idle, receiver stalling, both.
  // Each phase drains completely before the next one starts.
  int unsigned phase_send[4] = '{0, 48, 0, 11};
  int unsigned phase_recv[4] = '{0, 0, 48, 11};
  int unsigned phase_start;

  initial begin
    sh_status = '0;
    sh_word = '0;
    sh_build = '0;
    sh_frames = '0;
    sh_tape = 1'b0;
    sh_irq = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    for (int p = 0; p < 4; p++) begin
      @(posedge clk);
      send_idle_pct = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (p == 0) begin
        // The receiver holds off while events keep coming, so the unit
        // fills up and has to stall its input.
        hold_left = LONG_HOLD;
        push_directed();
      end
      phase_start = pushed_total;
      while (pushed_total - phase_start < ITEMS_PER_LOAD)
        push_session();
      do
        @(negedge clk);
      while (!(accepted_total == pushed_total && expected_replies.size() == 0));
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("replies still missing", 64'(expected_replies.size()), 64'd0);
    $display("Covered %0d events in four load phases with a long receiver hold-off;",
             accepted_total);
    $display("%0d replies checked, %0d data reads taken, %0d with an interrupt pending.",
             replies_checked, reads_taken, irq_replies);
    if (err_count == 0) begin
      $display("tb_paper_tape_reader_interface_unit: done, clean");
    end else begin
      $display("tb_paper_tape_reader_interface_unit: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ptri_pkg.sv
hw/rtl/paper_tape_reader_interface_unit.sv
hw/rtl/ptri_checker.sv
test/tb_paper_tape_reader_interface_unit.sv
